// ===== rtl/button_debounce_press_classifier_top_assert.svh =====
// Assertion macros shared by the debounce and press classifier RTL
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked check, switched off while reset is low
`define BDPC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bdpc: check failed");
// Clocked implication held only outside reset
`define BDPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdpc: implication failed");
`else
`define BDPC_ASSERT(label, clk, rst_n, prop)
`define BDPC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/bdpc_pkg.sv =====
// Types and constants of the button debounce and press classifier
`default_nettype none
package bdpc_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS = 2'd1;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_MS_RST = 16'd1000;

    // Press event codes
    typedef enum logic [1:0] {
        EVT_NONE  = 2'd0,
        EVT_SHORT = 2'd1,
        EVT_LONG  = 2'd2
    } t_event;

    // Timing settings handed to the classifier core
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
    } t_cfg;

endpackage
`default_nettype wire

// ===== rtl/button_debounce_press_classifier_top.sv =====
// A poll's press event is offered from the result register. Throughput: one
// poll per cycle while events are taken; the input register refills while the
// result register holds an untaken event, so stalls do not drop a poll.
// The press state updates as a poll moves from the input to the result register.
// Reset: synchronous, active low; state returns to released, registers to
// 50 ms debounce and 1000 ms long press.
`default_nettype none
`include "button_debounce_press_classifier_top_assert.svh"
module button_debounce_press_classifier_top #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bdpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bdpc_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [TIME_WIDTH-1:0]          i_now_ms,
    input  wire logic                           i_raw_level,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [1:0]                          o_press_event
);
    import bdpc_pkg::*;

    logic                  r_in_valid;
    logic [TIME_WIDTH-1:0] r_now_ms;
    logic                  r_raw_level;
    logic                  r_out_valid;
    t_event                r_event;

    logic                  w_advance;
    t_cfg                  w_cfg;
    t_event                w_event;

    // Poll moves on when the result register is free or being emptied
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    bdpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    bdpc_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_now_ms    (r_now_ms),
        .i_raw_level (r_raw_level),
        .i_cfg       (w_cfg),
        .o_event     (w_event)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_now_ms    <= i_now_ms;
            r_raw_level <= i_raw_level;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_event <= w_event;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_press_event = r_event;

    // A held poll is kept until it moves on
    `BDPC_ASSERT(a_poll_kept, i_clk, i_rst_n, (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_now_ms) && $stable(r_raw_level)))
    // Every processed poll lands in the result register
    `BDPC_ASSERT(a_result_loaded, i_clk, i_rst_n, w_advance |=> r_out_valid)
    // Back pressure only when both registers are occupied
    `BDPC_ASSERT_IMP(a_ready_full, i_clk, i_rst_n, !o_in_ready, r_in_valid && r_out_valid && !i_out_ready)

endmodule
`default_nettype wire

// ===== rtl/bdpc_cfg.sv =====
// Configuration registers of the debounce and press classifier
`default_nettype none
module bdpc_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bdpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bdpc_pkg::CFG_W-1:0]     i_cfg_data,
    output bdpc_pkg::t_cfg                      o_cfg
);
    import bdpc_pkg::*;

    logic [CFG_W-1:0] r_debounce_ms;
    logic [CFG_W-1:0] r_long_press_ms;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= DEBOUNCE_MS_RST;
            r_long_press_ms <= LONG_PRESS_MS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_MS:   r_debounce_ms   <= i_cfg_data;
                CFG_LONG_PRESS_MS: r_long_press_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.debounce_ms   = r_debounce_ms;
    assign o_cfg.long_press_ms = r_long_press_ms;

endmodule
`default_nettype wire

// ===== rtl/bdpc_core.sv =====
// Debounce state and press classification, updated once per request
`default_nettype none
`include "button_debounce_press_classifier_top_assert.svh"
module bdpc_core #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_advance,
    input  wire logic [TIME_WIDTH-1:0] i_now_ms,
    input  wire logic                  i_raw_level,
    input  bdpc_pkg::t_cfg             i_cfg,
    output bdpc_pkg::t_event           o_event
);
    import bdpc_pkg::*;

    // Compare width covers both elapsed time and the 16 bit thresholds
    localparam int unsigned CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

    logic                  r_last_raw;
    logic                  r_stable_level;
    logic [TIME_WIDTH-1:0] r_edge_time;
    logic [TIME_WIDTH-1:0] r_press_start;
    logic                  r_press_active;
    logic                  r_long_sent;

    logic                  n_stable_level;
    logic [TIME_WIDTH-1:0] n_edge_time;
    logic [TIME_WIDTH-1:0] n_press_start;
    logic                  n_press_active;
    logic                  n_long_sent;

    logic [TIME_WIDTH-1:0] w_deb_elapsed;
    logic [TIME_WIDTH-1:0] w_hold_elapsed;
    logic [TIME_WIDTH-1:0] w_hold_start;
    logic [CMP_W-1:0]      w_deb_cmp;
    logic [CMP_W-1:0]      w_hold_cmp;
    logic                  w_promote;
    logic                  w_press;
    logic                  w_release;
    logic                  w_hold_armed;
    logic                  w_long_hit;
    t_event                w_event;

    // A raw edge restarts the stability timer
    assign n_edge_time   = (i_raw_level != r_last_raw) ? i_now_ms : r_edge_time;
    assign w_deb_elapsed = i_now_ms - n_edge_time;
    assign w_deb_cmp     = CMP_W'(w_deb_elapsed);
    assign w_promote     = (r_stable_level != i_raw_level) &&
                           (w_deb_cmp >= CMP_W'(i_cfg.debounce_ms));
    assign w_press       = w_promote && !i_raw_level;
    assign w_release     = w_promote && i_raw_level;

    // Hold timer, measured from the press start as it stands after this poll
    assign w_hold_start   = w_press ? i_now_ms : r_press_start;
    assign w_hold_elapsed = i_now_ms - w_hold_start;
    assign w_hold_cmp     = CMP_W'(w_hold_elapsed);
    // A fresh press, or a held press with no long press reported yet
    assign w_hold_armed   = w_press ||
                            (!r_stable_level && r_press_active && !r_long_sent);
    assign w_long_hit     = !w_release && w_hold_armed &&
                            (w_hold_cmp >= CMP_W'(i_cfg.long_press_ms));

    // Debounced level change: open or close the press; mark a long press as reported
    always_comb begin
        n_stable_level = r_stable_level;
        n_press_start  = r_press_start;
        n_press_active = r_press_active;
        n_long_sent    = r_long_sent;
        if (w_promote) begin
            n_stable_level = i_raw_level;
            if (!i_raw_level) begin
                n_press_start  = i_now_ms;
                n_press_active = 1'b1;
                n_long_sent    = 1'b0;
            end else begin
                n_press_active = 1'b0;
            end
        end
        if (w_long_hit) begin
            n_long_sent = 1'b1;
        end
    end

    // Event for this request
    always_comb begin
        w_event = EVT_NONE;
        if (w_release) begin
            w_event = (r_press_active && !r_long_sent) ? EVT_SHORT : EVT_NONE;
        end else if (w_long_hit) begin
            w_event = EVT_LONG;
        end
    end

    assign o_event = w_event;

    // State update on each processed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw     <= 1'b1;
            r_stable_level <= 1'b1;
            r_edge_time    <= '0;
            r_press_start  <= '0;
            r_press_active <= 1'b0;
            r_long_sent    <= 1'b0;
        end else if (i_advance) begin
            r_last_raw     <= i_raw_level;
            r_stable_level <= n_stable_level;
            r_edge_time    <= n_edge_time;
            r_press_start  <= n_press_start;
            r_press_active <= n_press_active;
            r_long_sent    <= n_long_sent;
        end
    end

    // A press is open exactly while the debounced level is low
    `BDPC_ASSERT(a_active_tracks_level, i_clk, i_rst_n, r_press_active == !r_stable_level)
    // A long press leaves the press marked as reported
    `BDPC_ASSERT(a_long_marks_sent, i_clk, i_rst_n, (i_advance && w_event == EVT_LONG) |=> r_long_sent)
    // A short press comes only with a debounced release
    `BDPC_ASSERT(a_short_on_release, i_clk, i_rst_n, (i_advance && w_event == EVT_SHORT) |=> (r_stable_level && !r_press_active && !r_long_sent))

endmodule
`default_nettype wire

// ===== tb/button_debounce_press_classifier_top_tb.sv =====
// Self-checking testbench for the button debounce and short/long press classifier
module button_debounce_press_classifier_top_tb;
    import bdpc_pkg::*;

    localparam int unsigned TW              = 32;
    localparam int unsigned CYCLE_LIMIT     = 600000;
    localparam int unsigned SETTLE_CYCLES   = 6;
    localparam int unsigned PHASES          = 12;
    localparam int unsigned POLLS_PER_PHASE = 170;

    // Indexes with no register behind them; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_DEBOUNCE_MS;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    logic [TW-1:0]        i_now_ms      = '0;
    logic                 i_raw_level   = 1'b1;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b0;
    logic [1:0]           o_press_event;

    button_debounce_press_classifier_top #(.TIME_WIDTH(TW)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_now_ms      (i_now_ms),
        .i_raw_level   (i_raw_level),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_press_event (o_press_event)
    );

    // Directed stimulus rows: either a poll request or a register write
    typedef enum logic {ROW_POLL, ROW_CFG} t_row_kind;
    typedef struct {
        t_row_kind            kind;
        logic [TW-1:0]        now;
        logic                 raw;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        bit                   typed;
        t_event               want;
    } t_stim_row;

    t_stim_row   directed_rows[$];
    t_event      expected_events[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned polls_sent     = 0;
    int unsigned send_idle_pct  = 25;
    int unsigned recv_stall_pct = 25;
    bit          quiet          = 1'b0;

    // Shadow of the classifier state and its timing registers
    logic [CFG_W-1:0] mdl_debounce;
    logic [CFG_W-1:0] mdl_long;
    logic             mdl_last_raw;
    logic             mdl_stable;
    logic             mdl_active;
    logic             mdl_long_sent;
    logic [TW-1:0]    mdl_edge_time;
    logic [TW-1:0]    mdl_press_start;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Advance the shadow state by one poll and return the press event it gives
    function automatic t_event classify_poll(input logic [TW-1:0] now, input logic raw);
        logic [TW-1:0] since_edge;
        logic [TW-1:0] since_press;
        t_event        verdict;
        if (raw != mdl_last_raw) begin
            mdl_last_raw  = raw;
            mdl_edge_time = now;
        end
        since_edge = now - mdl_edge_time;
        if (mdl_stable != mdl_last_raw && since_edge >= TW'(mdl_debounce)) begin
            mdl_stable = mdl_last_raw;
            if (!mdl_stable) begin
                mdl_press_start = now;
                mdl_active      = 1'b1;
                mdl_long_sent   = 1'b0;
            end else begin
                // release poll decides the short press only
                verdict    = (mdl_active && !mdl_long_sent) ? EVT_SHORT : EVT_NONE;
                mdl_active = 1'b0;
                return verdict;
            end
        end
        since_press = now - mdl_press_start;
        if (!mdl_stable && mdl_active && !mdl_long_sent && since_press >= TW'(mdl_long)) begin
            mdl_long_sent = 1'b1;
            return EVT_LONG;
        end
        return EVT_NONE;
    endfunction

    function automatic void add_poll(input logic [TW-1:0] now, input logic raw);
        t_stim_row r;
        r = '{ROW_POLL, now, raw, CFG_DEBOUNCE_MS, '0, 1'b0, EVT_NONE};
        directed_rows.push_back(r);
    endfunction

    function automatic void add_checked(input logic [TW-1:0] now, input logic raw,
                                        input t_event want);
        t_stim_row r;
        r = '{ROW_POLL, now, raw, CFG_DEBOUNCE_MS, '0, 1'b1, want};
        directed_rows.push_back(r);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        t_stim_row r;
        r = '{ROW_CFG, '0, 1'b1, idx, val, 1'b0, EVT_NONE};
        directed_rows.push_back(r);
    endfunction

    // Register write; the block must be idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_DEBOUNCE_MS)
            mdl_debounce = val;
        else if (idx == CFG_LONG_PRESS_MS)
            mdl_long = val;
    endtask

    // Present one poll request, hold it until taken, then log its expected event
    task automatic send_poll(input logic [TW-1:0] now, input logic raw,
                             input bit typed, input t_event want);
        t_event predicted;
        if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_now_ms    <= now;
        i_raw_level <= raw;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = classify_poll(now, raw);
        expected_events.push_back(typed ? want : predicted);
        polls_sent++;
    endtask

    // Drop valid and let every outstanding event come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side back-pressure
    initial begin
        @(posedge i_clk);
        forever begin
            if (quiet || $urandom_range(0, 99) >= recv_stall_pct) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
        end
    end

    // Compare each accepted event with the oldest expectation
    always @(posedge i_clk) begin : check_events
        t_event want_evt;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_events.size() == 0) begin
                flag_mismatch($sformatf("unexpected press event %0d", o_press_event));
            end else begin
                want_evt = expected_events.pop_front();
                if (o_press_event !== want_evt)
                    flag_mismatch($sformatf("press event %0d, expected %0d",
                                            o_press_event, want_evt));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        logic [TW-1:0]    ts;
        logic             level;
        logic [CFG_W-1:0] deb;
        logic [CFG_W-1:0] lng;
        int unsigned      step_max;
        int unsigned      phase_start;

        mdl_debounce    = DEBOUNCE_MS_RST;
        mdl_long        = LONG_PRESS_MS_RST;
        mdl_last_raw    = 1'b1;
        mdl_stable      = 1'b1;
        mdl_active      = 1'b0;
        mdl_long_sent   = 1'b0;
        mdl_edge_time   = '0;
        mdl_press_start = '0;

        // Reset settings: released poll, long press, then a short press
        add_checked(32'd0, 1'b1, EVT_NONE);
        add_poll(32'd10, 1'b0);
        add_poll(32'd60, 1'b0);
        add_checked(32'd1060, 1'b0, EVT_LONG);
        add_poll(32'd1100, 1'b1);
        add_checked(32'd1150, 1'b1, EVT_NONE);
        add_poll(32'd2000, 1'b0);
        add_poll(32'd2050, 1'b0);
        add_poll(32'd2100, 1'b1);
        add_checked(32'd2150, 1'b1, EVT_SHORT);
        // bounce that settles back to released
        add_poll(32'd3000, 1'b0);
        add_poll(32'd3010, 1'b1);
        add_poll(32'd3100, 1'b1);
        // debounce and hold across the timestamp wrap
        add_poll(32'hFFFF_FFF0, 1'b0);
        add_poll(32'h0000_0022, 1'b0);
        add_checked(32'h0000_040A, 1'b0, EVT_LONG);
        add_poll(32'hFFFF_FFFF, 1'b1);
        add_checked(32'h0000_0031, 1'b1, EVT_NONE);
        // zero debounce and zero hold; press at timestamp zero
        add_reg(CFG_DEBOUNCE_MS, 16'd0);
        add_reg(CFG_LONG_PRESS_MS, 16'd0);
        add_reg(CFG_SPARE_A, 16'hFFFF);
        add_reg(CFG_SPARE_B, 16'h0001);
        add_checked(32'd0, 1'b0, EVT_LONG);
        add_checked(32'd5, 1'b1, EVT_NONE);
        // release poll past the hold time still gives a short press
        add_reg(CFG_LONG_PRESS_MS, 16'd100);
        add_poll(32'h8000_0000, 1'b0);
        add_checked(32'h8000_00C8, 1'b1, EVT_SHORT);
        // largest settings
        add_reg(CFG_DEBOUNCE_MS, 16'hFFFF);
        add_reg(CFG_LONG_PRESS_MS, 16'hFFFF);
        add_poll(32'd100, 1'b0);
        add_poll(32'd65634, 1'b0);
        add_poll(32'd65635, 1'b0);
        add_poll(32'd131170, 1'b0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                wait_idle();
                write_reg(directed_rows[k].idx, directed_rows[k].val);
            end else begin
                send_poll(directed_rows[k].now, directed_rows[k].raw,
                          directed_rows[k].typed, directed_rows[k].want);
            end
        end

        // Random phases, each under its own timing settings
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin
                    deb = DEBOUNCE_MS_RST;
                    lng = LONG_PRESS_MS_RST;
                end
                1: begin
                    deb = '0;
                    lng = '0;
                end
                2: begin
                    deb = '1;
                    lng = '1;
                end
                3: begin
                    deb = '0;
                    lng = '1;
                end
                4: begin
                    deb = '1;
                    lng = '0;
                end
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        deb = CFG_W'($urandom());
                        lng = CFG_W'($urandom());
                    end else begin
                        deb = CFG_W'($urandom_range(0, 40));
                        lng = CFG_W'($urandom_range(0, 400));
                    end
                end
            endcase
            write_reg(CFG_DEBOUNCE_MS, deb);
            write_reg(CFG_LONG_PRESS_MS, lng);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          CFG_W'($urandom()));

            quiet          = (p == PHASES - 1);
            send_idle_pct  = (p % 3 == 1) ? 0 : $urandom_range(5, 40);
            recv_stall_pct = (p % 3 == 1) ? 0 : $urandom_range(5, 40);

            step_max = (int'(deb) + int'(lng)) / 8 + 1;
            if ($urandom_range(0, 3) == 0)
                ts = 32'hFFFF_FFFF - $urandom_range(0, 4 * step_max);
            else
                ts = $urandom();
            level       = mdl_stable;
            phase_start = polls_sent;

            while (polls_sent - phase_start < POLLS_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: jump anywhere in time with any level
                    ts = $urandom();
                    send_poll(ts, 1'($urandom_range(0, 1)), 1'b0, EVT_NONE);
                end else begin
                    // contact bounce, then a steady hold at the new level
                    level = ~level;
                    repeat ($urandom_range(0, 4)) begin
                        ts += $urandom_range(0, step_max / 4);
                        send_poll(ts, 1'($urandom_range(0, 1)), 1'b0, EVT_NONE);
                    end
                    repeat ($urandom_range(1, 16)) begin
                        ts += $urandom_range(0, step_max);
                        send_poll(ts, level, 1'b0, EVT_NONE);
                    end
                end
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
